// ===== rtl/lnrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lnrs_pkg
// Shared types and constants of the letterbox NV12 scaler and RGB converter.
// ----------------------------------------------------------------------------
package lnrs_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;   // register and fitted-size width
    localparam int COORD_W       = 12;   // display coordinate width
    localparam int SRC_W         = 12;   // source column and row width
    localparam int PROD_W        = 26;   // product of two dimensions
    localparam int AREA_W        = 25;
    localparam int LIDX_W        = 24;
    localparam int CIDX_W        = 25;
    localparam int DIV_STEPS     = SRC_W;
    localparam int DIV_FIRST     = 3;    // stage of the first divide step
    localparam int NSTG          = DIV_FIRST + DIV_STEPS + 2;
    localparam int CFG_IDX_W     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DSP_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DSP_HEIGHT = 8'd3;

    // Request kinds carried in tuser.
    localparam logic OP_MAP     = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef logic [NSTG-1:0] stage_vec_t;

    // Fitted geometry; the user must keep it constant while items are in flight, as the block does not enforce this.
    typedef struct packed {
        logic               ready;
        logic               ok;
        logic [DIM_W-1:0]   sw;
        logic [DIM_W-1:0]   sh;
        logic [DIM_W-1:0]   scw;
        logic [DIM_W-1:0]   sch;
        logic [DIM_W-1:0]   ox;
        logic [DIM_W-1:0]   oy;
        logic [AREA_W-1:0]  area;
    } fit_t;

endpackage

// ===== rtl/lnrs_fit.sv =====
// ----------------------------------------------------------------------------
// lnrs_fit
// Configuration registers and the sequencer that works out the fitted picture
// size, centring offsets and luma plane size with a shared radix-2 divider.
// ----------------------------------------------------------------------------
module lnrs_fit import lnrs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output fit_t                 fit
);

    localparam logic [1:0] ST_START = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;
    localparam logic [4:0] CNT_LAST = 5'(PROD_W - 1);

    logic [1:0]        state_reg;
    logic [DIM_W-1:0]  sw_reg, sh_reg, dw_reg, dh_reg;
    logic [DIM_W-1:0]  scw_reg, sch_reg, ox_reg, oy_reg;
    logic [AREA_W-1:0] area_reg;
    logic              ok_reg, phase_reg;
    logic [PROD_W-1:0] n_reg, n_next;
    logic [DIM_W-1:0]  r_reg, r_next, d_reg;
    logic [4:0]        cnt_reg;
    logic [DIM_W:0]    rs;
    logic              ge;

    assign cfg_ready = 1'b1;

    // One quotient bit per cycle; the quotient shifts in behind the dividend.
    always_comb begin
        rs     = {r_reg, n_reg[PROD_W-1]};
        ge     = rs >= {1'b0, d_reg};
        r_next = ge ? DIM_W'(rs - {1'b0, d_reg}) : rs[DIM_W-1:0];
        n_next = {n_reg[PROD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            sw_reg    <= 13'd1920;
            sh_reg    <= 13'd1080;
            dw_reg    <= 13'd1920;
            dh_reg    <= 13'd1080;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_WIDTH:  sw_reg <= cfg_data;
                REG_SRC_HEIGHT: sh_reg <= cfg_data;
                REG_DSP_WIDTH:  dw_reg <= cfg_data;
                REG_DSP_HEIGHT: dh_reg <= cfg_data;
                default: ;
            endcase
            state_reg <= ST_START;
        end else begin
            case (state_reg)
                ST_START: begin
                    ok_reg    <= (sw_reg != '0) && (sh_reg != '0)
                                 && (sw_reg <= DIM_W'(MAX_DIMENSION))
                                 && (sh_reg <= DIM_W'(MAX_DIMENSION));
                    n_reg     <= PROD_W'(dw_reg * sh_reg);
                    d_reg     <= sw_reg;
                    r_reg     <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    r_reg   <= r_next;
                    n_reg   <= n_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CNT_LAST) begin
                        if (!phase_reg) begin
                            if (n_next > PROD_W'(dh_reg)) begin
                                // Height-limited: fit the width to the display height.
                                sch_reg   <= dh_reg;
                                n_reg     <= PROD_W'(dh_reg * sw_reg);
                                d_reg     <= sh_reg;
                                r_reg     <= '0;
                                cnt_reg   <= '0;
                                phase_reg <= 1'b1;
                            end else begin
                                scw_reg   <= dw_reg;
                                sch_reg   <= n_next[DIM_W-1:0];
                                state_reg <= ST_FIN;
                            end
                        end else begin
                            scw_reg   <= n_next[DIM_W-1:0];
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    ox_reg    <= DIM_W'((dw_reg - scw_reg) >> 1);
                    oy_reg    <= DIM_W'((dh_reg - sch_reg) >> 1);
                    area_reg  <= AREA_W'(sw_reg * sh_reg);
                    state_reg <= ST_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        fit.ready = (state_reg == ST_IDLE);
        fit.ok    = ok_reg;
        fit.sw    = sw_reg;
        fit.sh    = sh_reg;
        fit.scw   = scw_reg;
        fit.sch   = sch_reg;
        fit.ox    = ox_reg;
        fit.oy    = oy_reg;
        fit.area  = area_reg;
    end

endmodule

// ===== rtl/lnrs_map.sv =====
// ----------------------------------------------------------------------------
// lnrs_map
// Display-to-source mapping pipeline: offset and bounds test, scaling
// products, one divide step per stage, then the NV12 byte indices.
// ----------------------------------------------------------------------------
module lnrs_map import lnrs_pkg::*; (
    input  logic               aclk,
    input  stage_vec_t         en,
    input  fit_t               fit,
    input  logic               op_in,
    input  logic [COORD_W-1:0] px_in,
    input  logic [COORD_W-1:0] py_in,
    output logic               inside_res,
    output logic [LIDX_W-1:0]  luma_index,
    output logic [CIDX_W-1:0]  chroma_index
);

    logic               op_s0_reg;
    logic [COORD_W-1:0] px_s0_reg, py_s0_reg;
    logic               keep_s1_reg;
    logic [DIM_W-1:0]   rx_s1_reg, ry_s1_reg;
    logic               keep_s2_reg;
    logic [PROD_W-1:0]  nx_s2_reg, ny_s2_reg;

    logic               keep_reg [DIV_STEPS];
    logic [PROD_W-1:0]  remx_reg [DIV_STEPS];
    logic [PROD_W-1:0]  remy_reg [DIV_STEPS];
    logic [SRC_W-1:0]   qx_reg   [DIV_STEPS];
    logic [SRC_W-1:0]   qy_reg   [DIV_STEPS];
    logic [PROD_W-1:0]  remx_next [DIV_STEPS];
    logic [PROD_W-1:0]  remy_next [DIV_STEPS];
    logic [SRC_W-1:0]   qx_next   [DIV_STEPS];
    logic [SRC_W-1:0]   qy_next   [DIV_STEPS];

    logic               keep_s15_reg;
    logic [SRC_W-1:0]   sx_s15_reg;
    logic [AREA_W-1:0]  lp_s15_reg;
    logic [LIDX_W-1:0]  cp_s15_reg;
    logic               inside_s16_reg;
    logic [LIDX_W-1:0]  lidx_s16_reg;
    logic [CIDX_W-1:0]  cidx_s16_reg;

    logic               in_x, in_y;

    always_comb begin
        in_x = ({1'b0, px_s0_reg} >= fit.ox)
               && ({2'b0, px_s0_reg} < ({1'b0, fit.ox} + {1'b0, fit.scw}));
        in_y = ({1'b0, py_s0_reg} >= fit.oy)
               && ({2'b0, py_s0_reg} < ({1'b0, fit.oy} + {1'b0, fit.sch}));
    end

    // Restoring division with the divisor pre-shifted; the quotient is known
    // to stay below the source size, so twelve steps suffice.
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [PROD_W-1:0] src_x, src_y, trial_x, trial_y;
            logic [SRC_W-1:0]  sq_x, sq_y, bit_k;
            src_x   = (k == 0) ? nx_s2_reg : remx_reg[(k == 0) ? 0 : k-1];
            src_y   = (k == 0) ? ny_s2_reg : remy_reg[(k == 0) ? 0 : k-1];
            sq_x    = (k == 0) ? '0 : qx_reg[(k == 0) ? 0 : k-1];
            sq_y    = (k == 0) ? '0 : qy_reg[(k == 0) ? 0 : k-1];
            trial_x = PROD_W'(fit.scw) << (DIV_STEPS - 1 - k);
            trial_y = PROD_W'(fit.sch) << (DIV_STEPS - 1 - k);
            bit_k   = SRC_W'(1) << (DIV_STEPS - 1 - k);
            if (src_x >= trial_x) begin
                remx_next[k] = src_x - trial_x;
                qx_next[k]   = sq_x | bit_k;
            end else begin
                remx_next[k] = src_x;
                qx_next[k]   = sq_x;
            end
            if (src_y >= trial_y) begin
                remy_next[k] = src_y - trial_y;
                qy_next[k]   = sq_y | bit_k;
            end else begin
                remy_next[k] = src_y;
                qy_next[k]   = sq_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            op_s0_reg <= op_in;
            px_s0_reg <= px_in;
            py_s0_reg <= py_in;
        end
        if (en[1]) begin
            keep_s1_reg <= (op_s0_reg == OP_MAP) && fit.ok && in_x && in_y;
            rx_s1_reg   <= DIM_W'({1'b0, px_s0_reg} - fit.ox);
            ry_s1_reg   <= DIM_W'({1'b0, py_s0_reg} - fit.oy);
        end
        if (en[2]) begin
            keep_s2_reg <= keep_s1_reg;
            nx_s2_reg   <= PROD_W'(rx_s1_reg * fit.sw);
            ny_s2_reg   <= PROD_W'(ry_s1_reg * fit.sh);
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (en[DIV_FIRST + k]) begin
                keep_reg[k] <= (k == 0) ? keep_s2_reg : keep_reg[(k == 0) ? 0 : k-1];
                remx_reg[k] <= remx_next[k];
                remy_reg[k] <= remy_next[k];
                qx_reg[k]   <= qx_next[k];
                qy_reg[k]   <= qy_next[k];
            end
        end
        if (en[NSTG-2]) begin
            keep_s15_reg <= keep_reg[DIV_STEPS-1];
            sx_s15_reg   <= qx_reg[DIV_STEPS-1];
            lp_s15_reg   <= AREA_W'(qy_reg[DIV_STEPS-1] * fit.sw);
            cp_s15_reg   <= LIDX_W'(qy_reg[DIV_STEPS-1][SRC_W-1:1] * fit.sw);
        end
        if (en[NSTG-1]) begin
            inside_s16_reg <= keep_s15_reg;
            lidx_s16_reg   <= keep_s15_reg ? LIDX_W'(lp_s15_reg + AREA_W'(sx_s15_reg)) : '0;
            cidx_s16_reg   <= keep_s15_reg
                              ? CIDX_W'(fit.area + CIDX_W'(cp_s15_reg)
                                        + CIDX_W'({sx_s15_reg[SRC_W-1:1], 1'b0}))
                              : '0;
        end
    end

    assign inside_res   = inside_s16_reg;
    assign luma_index   = lidx_s16_reg;
    assign chroma_index = cidx_s16_reg;

endmodule

// ===== rtl/lnrs_yuv.sv =====
// ----------------------------------------------------------------------------
// lnrs_yuv
// BT.601 studio-range YUV to RGB conversion, timed to leave at the same
// stage as the mapping pipeline.
// ----------------------------------------------------------------------------
module lnrs_yuv import lnrs_pkg::*; (
    input  logic       aclk,
    input  stage_vec_t en,
    input  logic       op_in,
    input  logic [7:0] y_in,
    input  logic [7:0] u_in,
    input  logic [7:0] v_in,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    typedef struct packed {
        logic       op;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } yuv_t;

    localparam int DLY = NSTG - 2;

    yuv_t                dly_reg [DLY];
    logic                cvt_s15_reg;
    logic signed [19:0]  tc_s15_reg, rv_s15_reg, gu_s15_reg, gv_s15_reg, bu_s15_reg;
    logic [7:0]          r_s16_reg, g_s16_reg, b_s16_reg;
    logic signed [19:0]  c_s, u_s, v_s;

    function automatic logic [7:0] clamp8(input logic signed [19:0] s);
        logic signed [19:0] q;
        q = s >>> 8;
        if (q < 0)
            return 8'd0;
        else if (q > 20'sd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    always_comb begin
        c_s = $signed({12'd0, dly_reg[DLY-1].y}) - 20'sd16;
        u_s = $signed({12'd0, dly_reg[DLY-1].u}) - 20'sd128;
        v_s = $signed({12'd0, dly_reg[DLY-1].v}) - 20'sd128;
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DLY; k++) begin
            if (en[k]) begin
                if (k == 0)
                    dly_reg[k] <= '{op: op_in, y: y_in, u: u_in, v: v_in};
                else
                    dly_reg[k] <= dly_reg[(k == 0) ? 0 : k-1];
            end
        end
        if (en[NSTG-2]) begin
            cvt_s15_reg <= (dly_reg[DLY-1].op == OP_CONVERT);
            tc_s15_reg  <= c_s * 20'sd298 + 20'sd128;
            rv_s15_reg  <= v_s * 20'sd409;
            gu_s15_reg  <= u_s * 20'sd100;
            gv_s15_reg  <= v_s * 20'sd208;
            bu_s15_reg  <= u_s * 20'sd516;
        end
        if (en[NSTG-1]) begin
            r_s16_reg <= cvt_s15_reg ? clamp8(tc_s15_reg + rv_s15_reg) : '0;
            g_s16_reg <= cvt_s15_reg ? clamp8(tc_s15_reg - gu_s15_reg - gv_s15_reg) : '0;
            b_s16_reg <= cvt_s15_reg ? clamp8(tc_s15_reg + bu_s15_reg) : '0;
        end
    end

    assign red   = r_s16_reg;
    assign green = g_s16_reg;
    assign blue  = b_s16_reg;

endmodule

// ===== rtl/letterbox_nv12_to_rgb_scaler_core.sv =====
// ----------------------------------------------------------------------------
// letterbox_nv12_to_rgb_scaler_core
// Letterbox NV12 nearest-neighbour mapper and BT.601 YUV to RGB converter.
// ----------------------------------------------------------------------------
// Each input beat is either a map request (tuser 0), which turns a display
// coordinate into an inside flag and the NV12 luma and U byte indices of the
// nearest source sample, or a convert request (tuser 1), which turns a
// studio-range Y/U/V triple into clamped RGB. Every beat gives exactly one
// result beat. The datapath is a seventeen-stage pipeline that takes one beat
// per clock while the output is not stalled and the geometry is ready; the
// twelve divide stages of the source column and row set its length. Each
// stage holds its beat when the next one is full and stalled, so a stalled
// output only stops the input once the whole pipeline has filled.
// The fitted picture size and centring offsets are worked out by a sequencer
// with a one-bit-per-cycle divider after reset and after every configuration
// write; s_tready stays low meanwhile and rises once the sequencer is done,
// after a second division when the picture is limited by the display height.
// The configuration channel is always ready; indexes beyond the four
// registers are ignored.
// ----------------------------------------------------------------------------
module letterbox_nv12_to_rgb_scaler_core import lnrs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // display_x, display_y, luma, chroma_u, chroma_v
    input  logic                 s_tuser,   // op
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata    // inside_res, luma_index, chroma_index,
                                            // red, green, blue, zero pad
);

    fit_t             fit;
    stage_vec_t       en;
    logic [NSTG-1:0]  vld_reg;
    logic             inside_res;
    logic [LIDX_W-1:0] luma_index;
    logic [CIDX_W-1:0] chroma_index;
    logic [7:0]       red, green, blue;

    lnrs_fit u_fit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fit       (fit)
    );

    // A stage may load when it is empty or when its contents move on. The
    // enable ripples back from the output so bubbles are squeezed out.
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0] && fit.ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (en[i]) begin
                    if (i == 0)
                        vld_reg[i] <= s_tvalid && fit.ready;
                    else
                        vld_reg[i] <= vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    lnrs_map u_map (
        .aclk         (aclk),
        .en           (en),
        .fit          (fit),
        .op_in        (s_tuser),
        .px_in        (s_tdata[11:0]),
        .py_in        (s_tdata[23:12]),
        .inside_res   (inside_res),
        .luma_index   (luma_index),
        .chroma_index (chroma_index)
    );

    lnrs_yuv u_yuv (
        .aclk  (aclk),
        .en    (en),
        .op_in (s_tuser),
        .y_in  (s_tdata[31:24]),
        .u_in  (s_tdata[39:32]),
        .v_in  (s_tdata[47:40]),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {6'd0, blue, green, red, chroma_index, luma_index, inside_res};

endmodule
